@@ rtl/dpfc_pkg.sv @@
// Shared types and constants of the distortion filter chain.
`default_nettype none
package dpfc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_HP_COEFF     = 3'd0;
    localparam logic [2:0] REG_PRE_LP_COEFF = 3'd1;
    localparam logic [2:0] REG_DRIVE_GAIN   = 3'd2;
    localparam logic [2:0] REG_TONE_COEFF   = 3'd3;
    localparam logic [2:0] REG_VOLUME_SCALE = 3'd4;

    // Fixed-point constants of the chain (23 fraction bits; TANH_SCALE has 16 fraction bits).
    localparam logic signed [47:0] CLIP_LEVEL = 48'sd4613734;
    localparam logic signed [47:0] TANH_LIMIT = 48'sd25165824;
    localparam logic [15:0]        TANH_SCALE = 16'd52429;
    localparam logic [31:0]        ONE27      = 32'd226492416;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A, ST_B, ST_G, ST_T, ST_V, ST_H, ST_Z, ST_Q,
        ST_NUM, ST_DIV, ST_OUT
    } t_state;

    // Multiplier control state: busy flag and remaining multiplier bit count.
    typedef struct packed {
        logic        busy;
        logic [5:0]  bit_idx;
    } t_mul_ctl;

endpackage
`default_nettype wire

@@ rtl/distortion_pedal_filter_chain.sv @@
// Top level of the distortion chain: one shared bit-serial multiplier and divider.
// Each accepted item runs nine products on the shared multiplier (seven of 16 bits, two of 32
// bits), then 26 divider steps, and then loads the output register.
// A new item is accepted only after its result has moved to the output register; a result
// still held when the next one is done stalls.
// Reset (synchronous, active low) clears all filter memories and loads register defaults.
`default_nettype none
module distortion_pedal_filter_chain #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // sample_in
    input  wire logic        s_axis_tuser,                              // channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample_out
    output logic             m_axis_tuser,                          // channel_out
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int D  = SAMPLE_BITS - 24;
    localparam int DL = (D >= 0) ? D : 0;
    localparam int DR = (D < 0) ? -D : 0;
    localparam logic signed [47:0] OUT_MAX = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
    localparam logic signed [47:0] OUT_MIN = -(48'sd1 <<< (SAMPLE_BITS - 1));

    logic [15:0] r_hp, r_pre, r_drv, r_tone, r_vol;
    logic signed [31:0] r_hx [CHANNELS];
    logic signed [31:0] r_hy [CHANNELS];
    logic signed [31:0] r_pl [CHANNELS];
    logic signed [31:0] r_tp [CHANNELS];
    logic signed [31:0] r_ox [CHANNELS];
    logic signed [31:0] r_oy [CHANNELS];

    dpfc_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_ch;
    logic          r_chbit;
    logic signed [47:0] r_x, r_v;
    logic signed [47:0] r_w, n_w;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_num;
    logic [63:0] r_rem;
    logic [63:0] r_dsh;
    logic [33:0] r_den;
    logic [25:0] r_quo;
    logic [DW-1:0] r_out;
    logic        r_och;
    logic        r_oval;
    logic        out_load;
    logic        div_ge;

    logic        mul_start, mul_done;
    logic signed [47:0] mul_a;
    logic [31:0] mul_b;
    logic [5:0]  mul_bits;
    logic signed [79:0] mul_p;
    logic        r_wait;

    dpfc_serial_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .i_bits(mul_bits),
        .o_done(mul_done), .o_p(mul_p)
    );

    function automatic logic signed [47:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647)       return 48'sd2147483647;
        else if (v < -80'sd2147483648) return -48'sd2147483648;
        else                            return v[47:0];
    endfunction

    function automatic logic signed [79:0] rnd(input logic signed [79:0] v, input int s);
        logic signed [79:0] t;
        t = v + (80'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    // Scale the input sample to 23 fraction bits.
    logic signed [SAMPLE_BITS-1:0] s_in;
    logic signed [47:0] x_in;
    assign s_in = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign x_in = (48'(s_in) >>> DL) <<< DR;

    logic [CW-1:0] ch_sel;
    always_comb begin
        if (CHANNELS > 1 && 32'(s_axis_tuser) < CHANNELS) ch_sel = CW'(s_axis_tuser);
        else ch_sel = '0;
    end

    // Result of the stage whose product has just finished.
    logic signed [79:0] pr, pr8, pr14, z2;
    logic signed [47:0] zc;
    always_comb begin
        pr   = rnd(mul_p, 16);
        pr8  = rnd(mul_p, 8);
        pr14 = rnd(mul_p, 14);
        z2   = rnd(mul_p, 23);
        zc   = '0;
        n_w  = r_w;
        case (r_st)
            dpfc_pkg::ST_A: n_w = sat32(80'(r_x) - 80'(r_hx[r_ch]) + pr);
            dpfc_pkg::ST_B: n_w = sat32(80'(r_pl[r_ch]) + pr);
            dpfc_pkg::ST_G: begin
                if (pr8 > 80'(dpfc_pkg::CLIP_LEVEL))       n_w = dpfc_pkg::CLIP_LEVEL;
                else if (pr8 < -80'(dpfc_pkg::CLIP_LEVEL)) n_w = -dpfc_pkg::CLIP_LEVEL;
                else                                       n_w = pr8[47:0];
            end
            dpfc_pkg::ST_T: n_w = sat32(80'(r_tp[r_ch]) + pr);
            dpfc_pkg::ST_V: n_w = sat32(pr14);
            dpfc_pkg::ST_H: n_w = sat32(80'(r_v) - 80'(r_ox[r_ch]) + pr);
            dpfc_pkg::ST_Z: begin
                // Clamp to +-3.0, then keep the magnitude for the divider.
                if (pr > 80'(dpfc_pkg::TANH_LIMIT))       zc = dpfc_pkg::TANH_LIMIT;
                else if (pr < -80'(dpfc_pkg::TANH_LIMIT)) zc = -dpfc_pkg::TANH_LIMIT;
                else                                      zc = pr[47:0];
                n_w = zc[47] ? -zc : zc;
            end
            default: ;
        endcase
    end

    // Restoring divider step and output scaling.
    logic signed [47:0] yv, ys, yc;
    assign div_ge = (r_rem >= r_dsh);
    always_comb begin
        yv = r_neg ? -$signed(48'(r_quo)) : $signed(48'(r_quo));
        ys = (yv <<< DL) >>> DR;
        if (ys > OUT_MAX)      yc = OUT_MAX;
        else if (ys < OUT_MIN) yc = OUT_MIN;
        else                   yc = ys;
    end

    // The finished result moves to the output register once that is free.
    assign out_load = (r_st == dpfc_pkg::ST_OUT) && (!r_oval || m_axis_tready);

    // Sequencer: start each product, consume each result.
    always_comb begin
        n_st = r_st;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        mul_bits = 6'd16;
        case (r_st)
            dpfc_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_st = dpfc_pkg::ST_A;
            dpfc_pkg::ST_A: begin
                mul_a = 48'(r_hy[r_ch]); mul_b = 32'(r_hp);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_B;
            end
            dpfc_pkg::ST_B: begin
                mul_a = r_w - 48'(r_pl[r_ch]); mul_b = 32'(r_pre);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_G;
            end
            dpfc_pkg::ST_G: begin
                mul_a = r_w; mul_b = 32'(r_drv);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_T;
            end
            dpfc_pkg::ST_T: begin
                mul_a = r_w - 48'(r_tp[r_ch]); mul_b = 32'(r_tone);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_V;
            end
            dpfc_pkg::ST_V: begin
                mul_a = r_w; mul_b = 32'(r_vol);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_H;
            end
            dpfc_pkg::ST_H: begin
                mul_a = 48'(r_oy[r_ch]); mul_b = 32'(r_hp);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_Z;
            end
            dpfc_pkg::ST_Z: begin
                mul_a = r_w; mul_b = 32'(dpfc_pkg::TANH_SCALE);
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_Q;
            end
            dpfc_pkg::ST_Q: begin
                mul_a = r_w; mul_b = r_w[31:0]; mul_bits = 6'd32;
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_NUM;
            end
            dpfc_pkg::ST_NUM: begin
                mul_a = r_w; mul_b = r_num; mul_bits = 6'd32;
                mul_start = !r_wait;
                if (mul_done) n_st = dpfc_pkg::ST_DIV;
            end
            dpfc_pkg::ST_DIV: if (r_cnt == 5'd0) n_st = dpfc_pkg::ST_OUT;
            dpfc_pkg::ST_OUT: if (out_load) n_st = dpfc_pkg::ST_IDLE;
            default: n_st = dpfc_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_st == dpfc_pkg::ST_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_och;

    // Control, configuration registers and filter memories.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= dpfc_pkg::ST_IDLE;
            r_wait <= 1'b0;
            r_oval <= 1'b0;
            r_hp   <= 16'd65208;
            r_pre  <= 16'd8042;
            r_drv  <= 16'd3840;
            r_tone <= 16'd2523;
            r_vol  <= 16'd18022;
            for (int i = 0; i < CHANNELS; i++) begin
                r_hx[i] <= '0; r_hy[i] <= '0; r_pl[i] <= '0;
                r_tp[i] <= '0; r_ox[i] <= '0; r_oy[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (mul_start) r_wait <= 1'b1;
            else if (mul_done) r_wait <= 1'b0;
            if (out_load) r_oval <= 1'b1;
            else if (m_axis_tready) r_oval <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    dpfc_pkg::REG_HP_COEFF:     r_hp   <= i_cfg_wdata;
                    dpfc_pkg::REG_PRE_LP_COEFF: r_pre  <= i_cfg_wdata;
                    dpfc_pkg::REG_DRIVE_GAIN:   r_drv  <= i_cfg_wdata;
                    dpfc_pkg::REG_TONE_COEFF:   r_tone <= i_cfg_wdata;
                    dpfc_pkg::REG_VOLUME_SCALE: r_vol  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (mul_done) begin
                case (r_st)
                    dpfc_pkg::ST_A: begin
                        r_hx[r_ch] <= r_x[31:0];
                        r_hy[r_ch] <= n_w[31:0];
                    end
                    dpfc_pkg::ST_B: r_pl[r_ch] <= n_w[31:0];
                    dpfc_pkg::ST_T: r_tp[r_ch] <= n_w[31:0];
                    dpfc_pkg::ST_H: begin
                        r_ox[r_ch] <= r_v[31:0];
                        r_oy[r_ch] <= n_w[31:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_x <= x_in;
            r_ch <= ch_sel;
            r_chbit <= s_axis_tuser;
        end
        if (mul_done) r_w <= n_w;
        case (r_st)
            dpfc_pkg::ST_V: if (mul_done) r_v <= n_w;
            dpfc_pkg::ST_Z: if (mul_done) r_neg <= zc[47];
            dpfc_pkg::ST_Q: begin
                if (mul_done) begin
                    r_num <= dpfc_pkg::ONE27 + z2[31:0];
                    r_den <= 34'(dpfc_pkg::ONE27) + 34'(z2[31:0]) * 34'd9;
                end
            end
            dpfc_pkg::ST_NUM: begin
                // Numerator plus half the divisor, divisor aligned to the top quotient bit.
                if (mul_done) begin
                    r_rem <= 64'(mul_p) + 64'(r_den >> 1);
                    r_dsh <= 64'(r_den) << 25;
                    r_quo <= '0;
                    r_cnt <= 5'd25;
                end
            end
            dpfc_pkg::ST_DIV: begin
                if (div_ge) r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[24:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 5'd1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out <= DW'(yc[SAMPLE_BITS-1:0]);
            r_och <= r_chbit;
        end
    end

`ifndef SYNTHESIS
    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");
    // Accepting an item always starts the first filter stage.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_st == dpfc_pkg::ST_A))
        else $error("sequencer did not start");
    // No product is pending while the chain is idle.
    a_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == dpfc_pkg::ST_IDLE) |-> !r_wait)
        else $error("multiplier busy while idle");
`endif
endmodule
`default_nettype wire

@@ rtl/dpfc_serial_mul.sv @@
// Bit-serial signed by unsigned multiplier: one multiplier bit per cycle.
`default_nettype none
module dpfc_serial_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [47:0] i_a,
    input  wire logic [31:0]        i_b,
    input  wire logic [5:0]         i_bits,
    output logic                    o_done,
    output logic signed [79:0]      o_p
);
    dpfc_pkg::t_mul_ctl r_ctl, n_ctl;
    logic signed [79:0] r_acc, n_acc;
    logic signed [79:0] r_a, n_a;
    logic [31:0]        r_b, n_b;

    // One add of the shifted multiplicand per set multiplier bit.
    always_comb begin
        n_ctl = r_ctl;
        n_acc = r_acc;
        n_a   = r_a;
        n_b   = r_b;
        o_done = 1'b0;
        if (i_start) begin
            n_ctl.busy    = 1'b1;
            n_ctl.bit_idx = i_bits;
            n_acc = '0;
            n_a   = 80'(i_a);
            n_b   = i_b;
        end else if (r_ctl.busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_ctl.bit_idx = r_ctl.bit_idx - 6'd1;
            if (r_ctl.bit_idx == 6'd1) begin
                n_ctl.busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    // The last partial product is added on the way out.
    assign o_p = r_acc + ((r_ctl.busy && r_b[0]) ? r_a : 80'sd0);
endmodule
`default_nettype wire
